@@ hdl/cpv_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle polygon vertices package
// Shared constants and the CORDIC arctangent table in turn units.
// ----------------------------------------------------------------------------
package cpv_pkg;

  // Width of the CORDIC datapath for x and y, with headroom over Q1.30.
  localparam int unsigned CordicW = 34;
  // Width of the residual angle register.
  localparam int unsigned AngleW = 33;

  localparam logic signed [CordicW-1:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [CordicW-1:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [62:0] RoundHalf = 63'sd536870912;

  localparam int unsigned ResultCap = 64;

  // Rounded atan(2^-k) where a full turn is 2^32.
  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] a;
    unique case (k)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10680862;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/circle_polygon_vertices_unit.sv @@
// ----------------------------------------------------------------------------
// Circle polygon vertices unit
// Turns one circle request into the vertices of a regular polygon.
// ----------------------------------------------------------------------------
// One request (centre, radius, vertex count n) yields n vertices in order,
// each the centre plus the radius times the cosine and sine of i/n of a turn,
// in saturated signed Q16.16, the final one flagged by last_o. An invalid
// request yields a single transfer with status_o and last_o set. Each vertex
// passes in turn through the bit-serial phase divider, the shared CORDIC
// rotator, the two products through the single multiplier and the loading
// of the output register, which waits until the output is free. A new
// request is taken only once the last vertex has been loaded into the
// output register.
module circle_polygon_vertices_unit
  import cpv_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] radius_value_i,
  input  logic        [6:0]  segment_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic        [5:0]  point_index_o,
  output logic               last_o,
  output logic               status_o
);

  localparam int unsigned Limit = (MAX_SEGMENTS > ResultCap) ? ResultCap : MAX_SEGMENTS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT,
    ST_MULX,
    ST_MULY,
    ST_PUT
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0]        cx_q, cx_d, cy_q, cy_d, r_q, r_d;
  logic        [6:0]         n_q, n_d;
  logic        [5:0]         idx_q, idx_d;
  logic        [5:0]         rem_q, rem_d;
  logic        [4:0]         cnt_q, cnt_d;
  logic        [31:0]        quot_q, quot_d;
  logic                      err_q, err_d;
  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngleW-1:0]  z_q, z_d;
  logic        [1:0]         quad_q, quad_d;
  logic signed [62:0]        prod_q, prod_d;
  logic signed [31:0]        px_q, px_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [31:0]        point_x_q, point_x_d, point_y_q, point_y_d;
  logic        [5:0]         point_index_q, point_index_d;
  logic                      last_q, last_d, status_q, status_d;

  logic        [6:0]         rem2;
  logic                      qbit;
  logic        [6:0]         rem_sub;
  logic        [31:0]        phase;
  logic signed [CordicW-1:0] sh_x, sh_y;
  logic signed [AngleW-1:0]  ang;
  logic signed [CordicW-1:0] cc_w, ss_w;
  logic signed [31:0]        cc, ss, cos_t, sin_t, mul_in;
  logic signed [63:0]        prod;
  logic                      in_bad;
  logic                      is_last;
  logic                      out_free;

  function automatic logic signed [31:0] sat_coord(input logic signed [31:0] c,
                                                   input logic signed [62:0] p);
    logic signed [62:0] rnd;
    logic signed [32:0] term;
    logic signed [33:0] sum;
    logic signed [31:0] res;
    rnd  = p + RoundHalf;
    term = rnd[62:30];
    sum  = {{2{c[31]}}, c} + {term[32], term};
    if (sum > 34'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (sum < -34'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [CordicW-1:0] clamp_q30(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] res;
    if (v > OneQ30) begin
      res = OneQ30;
    end else if (v < -OneQ30) begin
      res = -OneQ30;
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_comb begin
    rem2    = {rem_q, 1'b0};
    qbit    = (rem2 >= n_q);
    rem_sub = rem2 - n_q;
    phase   = {quot_q[30:0], qbit};

    sh_x = x_q >>> cnt_q;
    sh_y = y_q >>> cnt_q;
    ang  = {3'b000, atan_turn(cnt_q)};

    cc_w = clamp_q30(x_q);
    ss_w = clamp_q30(y_q);
    cc   = cc_w[31:0];
    ss   = ss_w[31:0];
    case (quad_q)
      2'd0: begin
        cos_t = cc;
        sin_t = ss;
      end
      2'd1: begin
        cos_t = -ss;
        sin_t = cc;
      end
      2'd2: begin
        cos_t = -cc;
        sin_t = -ss;
      end
      default: begin
        cos_t = ss;
        sin_t = -cc;
      end
    endcase
    mul_in = (state_q == ST_MULX) ? cos_t : sin_t;
    prod   = r_q * mul_in;

    in_bad   = (radius_value_i <= 32'sd0) || (segment_count_i < 7'd3) ||
               (segment_count_i > 7'(Limit));
    is_last  = (({1'b0, idx_q} + 7'd1) == n_q);
    out_free = !out_valid_q || out_ready_i;

    state_d       = state_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    r_d           = r_q;
    n_d           = n_q;
    idx_d         = idx_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    quot_d        = quot_q;
    err_d         = err_q;
    x_d           = x_q;
    y_d           = y_q;
    z_d           = z_q;
    quad_d        = quad_q;
    prod_d        = prod_q;
    px_d          = px_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    point_x_d     = point_x_q;
    point_y_d     = point_y_q;
    point_index_d = point_index_q;
    last_d        = last_q;
    status_d      = status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cx_d  = center_x_i;
          cy_d  = center_y_i;
          r_d   = radius_value_i;
          n_d   = segment_count_i;
          idx_d = '0;
          rem_d = '0;
          cnt_d = '0;
          err_d = in_bad;
          state_d = in_bad ? ST_PUT : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? rem_sub[5:0] : rem2[5:0];
        quot_d = phase;
        if (cnt_q == 5'd31) begin
          cnt_d   = '0;
          x_d     = CordicGainQ30;
          y_d     = '0;
          z_d     = {3'b000, phase[29:0]};
          quad_d  = phase[31:30];
          state_d = ST_ROT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_ROT: begin
        if (!z_q[AngleW-1]) begin
          x_d = x_q - sh_y;
          y_d = y_q + sh_x;
          z_d = z_q - ang;
        end else begin
          x_d = x_q + sh_y;
          y_d = y_q - sh_x;
          z_d = z_q + ang;
        end
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_MULX;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_MULX: begin
        prod_d  = prod[62:0];
        state_d = ST_MULY;
      end
      ST_MULY: begin
        px_d    = sat_coord(cx_q, prod_q);
        prod_d  = prod[62:0];
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            point_x_d     = '0;
            point_y_d     = '0;
            point_index_d = '0;
            last_d        = 1'b1;
            status_d      = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            point_x_d     = px_q;
            point_y_d     = sat_coord(cy_q, prod_q);
            point_index_d = idx_q;
            last_d        = is_last;
            status_d      = 1'b0;
            if (is_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d   = idx_q + 6'd1;
              rem_d   = idx_q + 6'd1;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      err_q         <= 1'b0;
      cnt_q         <= '0;
      cx_q          <= '0;
      cy_q          <= '0;
      r_q           <= '0;
      n_q           <= '0;
      idx_q         <= '0;
      rem_q         <= '0;
      quot_q        <= '0;
      x_q           <= '0;
      y_q           <= '0;
      z_q           <= '0;
      quad_q        <= '0;
      prod_q        <= '0;
      px_q          <= '0;
      point_x_q     <= '0;
      point_y_q     <= '0;
      point_index_q <= '0;
      last_q        <= 1'b0;
      status_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      err_q         <= err_d;
      cnt_q         <= cnt_d;
      cx_q          <= cx_d;
      cy_q          <= cy_d;
      r_q           <= r_d;
      n_q           <= n_d;
      idx_q         <= idx_d;
      rem_q         <= rem_d;
      quot_q        <= quot_d;
      x_q           <= x_d;
      y_q           <= y_d;
      z_q           <= z_d;
      quad_q        <= quad_d;
      prod_q        <= prod_d;
      px_q          <= px_d;
      point_x_q     <= point_x_d;
      point_y_q     <= point_y_d;
      point_index_q <= point_index_d;
      last_q        <= last_d;
      status_q      <= status_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign point_index_o = point_index_q;
  assign last_o        = last_q;
  assign status_o      = status_q;

  // An accepted request always makes the sequencer busy: in_ready_o falls after acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted but block ready again at once");

  // While a vertex other than the final one is offered, the request is unfinished.
  a_not_ready_mid_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("block ready while a request still has vertices to give");

  // An error transfer is a single, empty, final result.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && (point_index_o == 6'd0) &&
    (point_x_o == 32'sd0) && (point_y_o == 32'sd0))
    else $error("error transfer with unexpected fields");

endmodule
